[design/ket_pkg.sv]
// Package for the keyed entry table: request and status codes, field widths
// and the stored entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ket_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

[design/ket_store.sv]
// Slot storage for the keyed entry table: one write port, one registered
// read port. Uses ket_pkg::entry_t.
`timescale 1ns / 1ps
`default_nettype none

module ket_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire ket_pkg::entry_t   wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output ket_pkg::entry_t        rd_data
);

  ket_pkg::entry_t mem [DEPTH];
  ket_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/keyed_entry_table_core.sv]
// Top level of the keyed entry table: request sequencer, shared key compare
// and result register. Depends on ket_pkg and ket_store.
`timescale 1ns / 1ps
`default_nettype none

// Keyed entry table. Holds up to CAPACITY key/value entries in age order,
// oldest at slot 0; a fill count marks the live prefix and is cleared at
// reset, so no clearing pass is needed. One request is handled at a time and
// in_stall is high until it is finished. All slot reads go through a
// single read port and a single 32-bit key comparator. An insert writes
// its entry and then responds; an insert into a full table, or a lookup
// or delete on an empty table, goes straight to the response step. A
// lookup or delete walks the table from the newest entry down, one entry
// per cycle, and examines at most the fill count of entries. A delete that
// hits below the newest entry then shifts the younger entries down, one
// per cycle, before it responds. The result waits in an output register
// until taken.
module keyed_entry_table_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ket_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [ket_pkg::KEY_W-1:0]    in_key,
  input  wire logic [ket_pkg::VAL_W-1:0]    in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ket_pkg::STAT_W-1:0]        out_status,
  output logic [ket_pkg::VAL_W-1:0]         out_found_value
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [ket_pkg::REQ_W-1:0]   req_r;
  logic [ket_pkg::KEY_W-1:0]   key_r;
  logic [ket_pkg::VAL_W-1:0]   val_r;
  logic [IDX_W-1:0]            scan_r, scan_nxt;
  logic [IDX_W-1:0]            src_r, src_nxt;
  logic                        more_r, more_nxt;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic [ket_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [ket_pkg::VAL_W-1:0]   res_val_r, res_val_nxt;
  logic                        out_valid_r;
  logic [ket_pkg::STAT_W-1:0]  out_status_r;
  logic [ket_pkg::VAL_W-1:0]   out_val_r;

  logic                        accept;
  logic                        hit;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  ket_pkg::entry_t             wr_data;
  ket_pkg::entry_t             rd_data;
  logic                        full;
  logic [CNT_W-1:0]            hit_next;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign hit      = rd_vld_r && (rd_data.key == key_r);
  assign hit_next = CNT_W'(rd_idx_r) + CNT_W'(1);

  // Read port: scan downward while searching, upward while shifting.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_r;
    if (state_r == S_SRCH) begin
      rd_en = more_r && !hit;
    end else if (state_r == S_SHIFT) begin
      rd_en   = more_r;
      rd_addr = src_r;
    end
  end

  // Write port: append on insert, move an entry down one slot while shifting.
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data.key   = key_r;
    wr_data.value = val_r;
    if (state_r == S_INS) begin
      wr_en = 1'b1;
    end else if (state_r == S_SHIFT && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r - IDX_W'(1);
      wr_data = rd_data;
    end
  end

  ket_store #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    src_nxt        = src_r;
    more_nxt       = more_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_val_nxt = '0;
          if (in_req_type == ket_pkg::REQ_INSERT) begin
            if (full) begin
              res_status_nxt = ket_pkg::ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_INS;
            end
          end else if (count_r == '0) begin
            res_status_nxt = ket_pkg::ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end else begin
            scan_nxt  = IDX_W'(count_r - CNT_W'(1));
            more_nxt  = 1'b1;
            state_nxt = S_SRCH;
          end
        end
      end
      S_INS: begin
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = ket_pkg::ST_OK;
        state_nxt      = S_RESP;
      end
      S_SRCH: begin
        if (more_r && !hit) begin
          if (scan_r == '0) begin
            more_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r - IDX_W'(1);
          end
        end
        if (hit) begin
          res_status_nxt = ket_pkg::ST_OK;
          res_val_nxt    = rd_data.value;
          if (req_r != ket_pkg::REQ_DELETE) begin
            state_nxt = S_RESP;
          end else if (hit_next == count_r) begin
            // Newest entry removed: nothing above it to move.
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESP;
          end else begin
            src_nxt   = IDX_W'(hit_next);
            more_nxt  = 1'b1;
            state_nxt = S_SHIFT;
          end
        end else if (rd_vld_r && !more_r) begin
          res_status_nxt = ket_pkg::ST_NOT_FOUND;
          res_val_nxt    = '0;
          state_nxt      = S_RESP;
        end
      end
      S_SHIFT: begin
        if (more_r) begin
          if (CNT_W'(src_r) == count_r - CNT_W'(1)) begin
            more_nxt = 1'b0;
          end else begin
            src_nxt = src_r + IDX_W'(1);
          end
        end else if (!rd_vld_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      more_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      more_r   <= more_nxt;
      rd_vld_r <= rd_en;
      if (state_r == S_RESP && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    src_r        <= src_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (accept) begin
      req_r <= in_req_type;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (state_r == S_RESP && (!out_valid_r || !out_stall)) begin
      out_status_r <= res_status_r;
      out_val_r    <= res_val_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_val_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r + CNT_W'(1) == $past(count_r)))
    else $error("fill count moved by more than one");

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result presented outside the response step");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ket_pkg::ST_OK) |-> (out_val_r == '0))
    else $error("nonzero value with a failing status");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_status_r == ket_pkg::ST_FULL) |-> full)
    else $error("full status with free slots");

  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r != S_INS) |-> (state_r == S_SHIFT && rd_idx_r != '0))
    else $error("stray slot write");

endmodule

`default_nettype wire

[dv/keyed_entry_table_core_tb.sv]
// Testbench for keyed_entry_table_core: directed and random lookup, insert and
// delete requests, checked against a behavioral table model in a scoreboard.
// Depends on ket_pkg and the keyed_entry_table_core RTL.
`timescale 1ns / 1ps

module keyed_entry_table_core_tb;

  localparam int TABLE_DEPTH     = 16;
  localparam int RANDOM_REQUESTS = 500;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 60;

  // Encoding left unused by the package; the block treats it as a lookup.
  localparam logic [ket_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  // Age-ordered entry table plus the queue of responses it predicts.
  class entry_table_model;
    logic [ket_pkg::KEY_W-1:0]  slot_key [TABLE_DEPTH];
    logic [ket_pkg::VAL_W-1:0]  slot_val [TABLE_DEPTH];
    int                         fill;
    logic [ket_pkg::STAT_W-1:0] status_q [$];
    logic [ket_pkg::VAL_W-1:0]  value_q [$];
    int errors, checked, hits, misses, fulls, inserts, deletes;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      fulls = 0;
      inserts = 0;
      deletes = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_request(logic [ket_pkg::REQ_W-1:0] req,
                               logic [ket_pkg::KEY_W-1:0] k,
                               logic [ket_pkg::VAL_W-1:0] v);
      int                         hit;
      int                         i;
      logic [ket_pkg::STAT_W-1:0] st;
      logic [ket_pkg::VAL_W-1:0]  fv;
      st = ket_pkg::ST_OK;
      fv = '0;
      hit = -1;
      if (req == ket_pkg::REQ_INSERT) begin
        inserts++;
        if (fill >= TABLE_DEPTH) begin
          st = ket_pkg::ST_FULL;
          fulls++;
        end else begin
          slot_key[fill] = k;
          slot_val[fill] = v;
          fill++;
        end
      end else begin
        // Search from the newest entry down.
        for (i = fill - 1; i >= 0; i--) begin
          if (hit < 0 && slot_key[i] == k) hit = i;
        end
        if (hit < 0) begin
          st = ket_pkg::ST_NOT_FOUND;
          misses++;
        end else begin
          fv = slot_val[hit];
          hits++;
          if (req == ket_pkg::REQ_DELETE) begin
            deletes++;
            for (i = hit; i < fill - 1; i++) begin
              slot_key[i] = slot_key[i + 1];
              slot_val[i] = slot_val[i + 1];
            end
            fill--;
          end
        end
      end
      status_q.push_back(st);
      value_q.push_back(fv);
    endfunction

    function void check_result(logic [ket_pkg::STAT_W-1:0] st,
                               logic [ket_pkg::VAL_W-1:0] fv);
      logic [ket_pkg::STAT_W-1:0] exp_st;
      logic [ket_pkg::VAL_W-1:0]  exp_fv;
      if (status_q.size() == 0) begin
        $display("%0t: response with none pending: status %0d found_value %h",
                 $time, st, fv);
        errors++;
        return;
      end
      exp_st = status_q.pop_front();
      exp_fv = value_q.pop_front();
      checked++;
      if (st !== exp_st) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, exp_st, st);
        errors++;
      end
      if (fv !== exp_fv) begin
        $display("%0t: found_value mismatch: expected %h actual %h",
                 $time, exp_fv, fv);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [ket_pkg::REQ_W-1:0]  in_req_type;
  logic [ket_pkg::KEY_W-1:0]  in_key;
  logic [ket_pkg::VAL_W-1:0]  in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [ket_pkg::STAT_W-1:0] out_status;
  logic [ket_pkg::VAL_W-1:0]  out_found_value;

  entry_table_model           table_model;
  logic [ket_pkg::KEY_W-1:0]  key_pool [8];
  int                         cycle_count;
  int                         sent;
  int                         burst_len;
  int                         seg_left;
  int                         insert_pct;
  int                         gap_pick;
  int                         i;

  stall_mode_t                stall_mode;
  int                         mode_left;
  int                         hold_left;
  int                         stall_phase;

  keyed_entry_table_core #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending",
               cycle_count, table_model.pending());
      $display("keyed_entry_table_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) table_model.check_result(out_status, out_found_value);
  end

  // Receiver backpressure: switch between stall patterns every so often.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 1) == 1);
        end
        STALL_PERIODIC: begin
          out_stall <= (stall_phase % 5) < 3;
        end
        default: begin
          if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) hold_left <= $urandom_range(5, 20);
          end
        end
      endcase
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [ket_pkg::REQ_W-1:0] req,
                              logic [ket_pkg::KEY_W-1:0] k,
                              logic [ket_pkg::VAL_W-1:0] v);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    table_model.note_request(req, k, v);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold the sender until every pending response has come back.
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(negedge clk);
    while (table_model.pending() != 0) @(negedge clk);
  endtask

  task automatic random_request();
    logic [ket_pkg::REQ_W-1:0] req;
    logic [ket_pkg::KEY_W-1:0] k;
    logic [ket_pkg::VAL_W-1:0] v;
    int                        pick;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      req = ket_pkg::REQ_INSERT;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) req = ket_pkg::REQ_LOOKUP;
      else if (pick < 9) req = ket_pkg::REQ_DELETE;
      else req = REQ_UNUSED;
    end
    // Mostly reuse a small key set so lookups and deletes hit.
    if ($urandom_range(0, 3) != 0) k = key_pool[$urandom_range(0, 7)];
    else k = $urandom;
    pick = $urandom_range(0, 15);
    if (pick == 0) v = '0;
    else if (pick == 1) v = '1;
    else v = {$urandom, $urandom};
    send_request(req, k, v);
  endtask

  initial begin
    table_model = new();
    cycle_count = 0;
    stall_mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    stall_phase = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = ket_pkg::REQ_LOOKUP;
    in_key = '0;
    in_value = '0;
    out_stall = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < 8; i++) key_pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, then extremes, duplicates and a delete below the newest.
    send_request(ket_pkg::REQ_LOOKUP, '0, '1);
    send_request(ket_pkg::REQ_DELETE, '1, '0);
    send_request(ket_pkg::REQ_INSERT, '0, '0);
    send_request(ket_pkg::REQ_INSERT, '1, '1);
    send_request(ket_pkg::REQ_INSERT, '0, 64'h5555_5555_5555_5555);
    send_request(ket_pkg::REQ_LOOKUP, '0, '0);
    send_request(REQ_UNUSED, '1, '0);
    send_request(ket_pkg::REQ_DELETE, '1, '0);
    send_request(ket_pkg::REQ_DELETE, '0, '0);
    send_request(ket_pkg::REQ_LOOKUP, '0, '0);
    send_request(REQ_UNUSED, 32'h1234_5678, '0);
    // Fill to capacity, overflow once, then delete the oldest entry.
    for (i = 1; i < TABLE_DEPTH; i++) begin
      send_request(ket_pkg::REQ_INSERT, i, {$urandom, $urandom});
    end
    send_request(ket_pkg::REQ_INSERT, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ket_pkg::REQ_DELETE, '0, '0);
    drain_pause();

    sent = 0;
    seg_left = 0;
    insert_pct = 45;
    while (sent < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(1, 24);
      while (burst_len > 0 && sent < RANDOM_REQUESTS) begin
        // Shift the insert rate so the table both fills up and drains.
        if (seg_left == 0) begin
          case ($urandom_range(0, 2))
            0: insert_pct = 20;
            1: insert_pct = 45;
            default: insert_pct = 75;
          endcase
          seg_left = $urandom_range(30, 70);
        end
        random_request();
        seg_left--;
        burst_len--;
        sent++;
        if (sent == RANDOM_REQUESTS / 2) drain_pause();
      end
      gap_pick = $urandom_range(0, 9);
      if (gap_pick >= 3 && gap_pick < 9) idle_cycles($urandom_range(1, 6));
      else if (gap_pick == 9) idle_cycles($urandom_range(20, 40));
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (table_model.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d inserts (%0d refused as full), %0d deletes",
             table_model.checked, table_model.inserts, table_model.fulls,
             table_model.deletes);
    $display("Searches: %0d hits, %0d misses; %0d errors",
             table_model.hits, table_model.misses, table_model.errors);
    if (table_model.errors == 0 && table_model.pending() == 0) begin
      $display("keyed_entry_table_core verification clean");
    end else begin
      $display("keyed_entry_table_core verification failed");
    end
    $finish;
  end

endmodule

[keyed_entry_table_core.f]
design/ket_pkg.sv
design/ket_store.sv
design/keyed_entry_table_core.sv
dv/keyed_entry_table_core_tb.sv
